// ===== rtl/core/assert_macros.svh =====
// assertion macros used by spring_bungee_force_2d
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/sbf2d_pkg.sv =====
// package for the 2d spring force pipeline: widths, register indexes, configuration types
// no dependencies
`default_nettype none
package sbf2d_pkg;
  localparam int FracBitsDefault = 16;
  localparam int PosW   = 32;
  localparam int DiffW  = 33;
  localparam int MagW   = 32;   // |d| < 2^32
  localparam int SqW    = 65;   // sum of squares < 2^65
  localparam int LenW   = 33;   // sqrt < 2^33 (len <= 2^32.5)
  localparam int StrW   = 34;
  localparam int MW     = 66;   // 32 x 34 product
  localparam int QW     = 33;   // saturated quotient, 2^32-1 plus
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPRING_MODE     = 2'd0,
    REG_REST_LENGTH     = 2'd1,
    REG_SPRING_CONSTANT = 2'd2,
    REG_UNUSED          = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic mode;
    logic [31:0] rest;
    logic [31:0] kconst;
  } cfg_t;
endpackage
`default_nettype wire

// ===== rtl/core/spring_bungee_force_2d.sv =====
// spring_bungee_force_2d: hooke spring / bungee force on a particle
// input beat: two positions; output beat: force pair and active flag.
// every stage advances together when the output register is free or taken.
// stages in order: differences, squares, the root, stretch, scale, two product
// stages, the two dividers side by side, and the output register.
// one pair accepted per cycle while the output register is free or taken; a single global enable moves all stages.
// configuration writes (wr_en, wr_addr, wr_data) must occur while idle.
// reset (rst, synchronous) clears the configuration registers to zero and all valid bits.
// when the receiver holds m_tready low, the output beat holds and the whole
// pipeline freezes; s_tready drops with it, so nothing is lost or repeated.
// radix: one root bit per stage, one quotient bit per divider stage.
// s_tdata: particle_x, particle_y, other_x, other_y (lowest first).
// m_tdata: force_x, force_y. m_tuser: force_active.
`default_nettype none
`include "assert_macros.svh"
module spring_bungee_force_2d
  import sbf2d_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [127:0]        s_tdata,  // particle_x, particle_y, other_x, other_y
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [63:0]              m_tdata,  // force_x, force_y
  output logic                     m_tuser,  // force_active
  input  wire logic                wr_en,
  input  wire logic [CfgIdxW-1:0]  wr_addr,
  input  wire logic [CfgDataW-1:0] wr_data
);
  cfg_t cfg;
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_addr))
        REG_SPRING_MODE:     cfg.mode   <= wr_data[0];
        REG_REST_LENGTH:     cfg.rest   <= wr_data;
        REG_SPRING_CONSTANT: cfg.kconst <= wr_data;
        default: ;
      endcase
    end
  end

  // stage 1: differences
  logic             v1;
  logic signed [DiffW-1:0] dx1, dy1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= {s_tdata[31], s_tdata[31:0]}  - {s_tdata[95], s_tdata[95:64]};
      dy1 <= {s_tdata[63], s_tdata[63:32]} - {s_tdata[127], s_tdata[127:96]};
    end
  end

  // stage 2: squares (33x33 signed, within the multiplier budget)
  logic          v2;
  logic [SqW-1:0] sx2, sy2;
  logic signed [DiffW-1:0] dx2, dy2;
  logic signed [2*DiffW-1:0] sqx1, sqy1;
  assign sqx1 = dx1 * dx1;
  assign sqy1 = dy1 * dy1;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx2 <= sqx1[SqW-1:0];
      sy2 <= sqy1[SqW-1:0];
      dx2 <= dx1;
      dy2 <= dy1;
    end
  end

  localparam int SW = 2 * DiffW;
  logic [SW-1:0] sq_side;
  logic          vr;
  logic [LenW-1:0] len_r;
  sbf2d_sqrt #(.SideW(SW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .radicand(sx2 + sy2), .side_in({dx2, dy2}),
    .out_valid(vr), .root(len_r), .side_out(sq_side)
  );

  // stage m1: stretch and magnitudes
  logic              vm1;
  logic [LenW-1:0]   len_m1;
  logic [StrW-1:0]   astr_m1;
  logic              sneg_m1, slack_m1;
  logic signed [DiffW-1:0] dx_m1, dy_m1;
  logic signed [StrW-1:0] stretch;
  assign stretch = $signed({1'b0, len_r}) - $signed({2'b00, cfg.rest});
  always_ff @(posedge clk) begin
    if (rst) vm1 <= 1'b0;
    else if (en) vm1 <= vr;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      len_m1   <= len_r;
      sneg_m1  <= stretch[StrW-1];
      astr_m1  <= stretch[StrW-1] ? StrW'(-stretch) : StrW'(stretch);
      slack_m1 <= cfg.mode && (stretch[StrW-1] || stretch == '0);
      dx_m1    <= sq_side[SW-1 -: DiffW];
      dy_m1    <= sq_side[DiffW-1:0];
    end
  end

  // stage m2: k * |stretch|, scaled
  logic            vm2;
  logic [MW-1:0]   m_m2;
  logic [LenW-1:0] len_m2;
  logic            sneg_m2, slack_m2;
  logic [MagW:0]   ax_m2, ay_m2;
  logic            xneg_m2, yneg_m2;
  logic [MW-1:0]   prod;
  assign prod = {{(MW-32){1'b0}}, cfg.kconst} * {{(MW-StrW){1'b0}}, astr_m1};
  always_ff @(posedge clk) begin
    if (rst) vm2 <= 1'b0;
    else if (en) vm2 <= vm1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_m2     <= prod >> FRAC_BITS;
      len_m2   <= len_m1;
      sneg_m2  <= sneg_m1;
      slack_m2 <= slack_m1;
      xneg_m2  <= dx_m1[DiffW-1];
      yneg_m2  <= dy_m1[DiffW-1];
      ax_m2    <= dx_m1[DiffW-1] ? (MagW+1)'(-dx_m1) : (MagW+1)'(dx_m1);
      ay_m2    <= dy_m1[DiffW-1] ? (MagW+1)'(-dy_m1) : (MagW+1)'(dy_m1);
    end
  end

  // stage m3: m * |d|, cut as 66 x 33 into two halves of m
  logic            vm3;
  logic [MW+MagW:0] nx_m3, ny_m3;
  logic [LenW-1:0] len_m3;
  logic            sneg_m3, slack_m3, xneg_m3, yneg_m3;
  logic [65:0] plx, phx, ply, phy;
  always_comb begin
    plx = {33'd0, m_m2[32:0]} * {33'd0, ax_m2};
    phx = {33'd0, m_m2[65:33]} * {33'd0, ax_m2};
    ply = {33'd0, m_m2[32:0]} * {33'd0, ay_m2};
    phy = {33'd0, m_m2[65:33]} * {33'd0, ay_m2};
  end
  logic [65:0] plx_r, phx_r, ply_r, phy_r;
  logic        vm3a, sneg_a, slack_a, xneg_a, yneg_a;
  logic [LenW-1:0] len_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm3a <= 1'b0;
      vm3  <= 1'b0;
    end else if (en) begin
      vm3a <= vm2;
      vm3  <= vm3a;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      plx_r <= plx; phx_r <= phx; ply_r <= ply; phy_r <= phy;
      len_a <= len_m2; sneg_a <= sneg_m2; slack_a <= slack_m2;
      xneg_a <= xneg_m2; yneg_a <= yneg_m2;
      nx_m3 <= (99'(phx_r) << 33) + 99'(plx_r);
      ny_m3 <= (99'(phy_r) << 33) + 99'(ply_r);
      len_m3 <= len_a; sneg_m3 <= sneg_a; slack_m3 <= slack_a;
      xneg_m3 <= xneg_a; yneg_m3 <= yneg_a;
    end
  end

  // dividers; zero length gives an all-ones quotient, masked afterward
  localparam int DSW = 4;
  logic vdx, vdy;
  logic [31:0] qx, qy;
  logic [DSW-1:0] dsx, dsy;
  logic len_zero;
  assign len_zero = (len_m3 == '0);
  sbf2d_div #(.SideW(DSW)) u_divx (
    .clk(clk), .rst(rst), .en(en), .in_valid(vm3),
    .dividend(nx_m3), .divisor(len_m3),
    .side_in({slack_m3, len_zero, sneg_m3, xneg_m3}),
    .out_valid(vdx), .quot(qx), .side_out(dsx)
  );
  sbf2d_div #(.SideW(DSW)) u_divy (
    .clk(clk), .rst(rst), .en(en), .in_valid(vm3),
    .dividend(ny_m3), .divisor(len_m3),
    .side_in({slack_m3, len_zero, sneg_m3, yneg_m3}),
    .out_valid(vdy), .quot(qy), .side_out(dsy)
  );

  function automatic logic [31:0] sat_comp(input logic [31:0] q, input logic [3:0] sd);
    logic neg;
    neg = (sd[0] == sd[1]);
    if (sd[3] || sd[2] || q == '0) return '0;
    if (neg) return (q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
    return (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vdx;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {sat_comp(qy, dsy), sat_comp(qx, dsx)};
      m_tuser <= !dsx[3];
    end
  end

  `ASSERT_IMPL(a_div_lockstep, clk, rst, 1'b1, vdx == vdy)
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPL(a_slack_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
endmodule
`default_nettype wire

// ===== rtl/core/sbf2d_sqrt.sv =====
// pipelined integer square root of a 65-bit value, one result bit per stage
// depends on sbf2d_pkg; carries a sideband payload alongside
`default_nettype none
module sbf2d_sqrt
  import sbf2d_pkg::*;
#(
  parameter int SideW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SqW-1:0]    radicand,
  input  wire logic [SideW-1:0]  side_in,
  output logic                   out_valid,
  output logic [LenW-1:0]        root,
  output logic [SideW-1:0]       side_out
);
  localparam int N = LenW;
  // restoring method, remainder form: stage b decides bit (N-1-b)
  logic [N:0]         vld;
  logic [SqW+1:0]     rem   [N+1];
  logic [LenW-1:0]    res   [N+1];
  logic [SqW+1:0]     rad   [N+1];
  logic [SideW-1:0]   side  [N+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    res[0]  = '0;
    rad[0]  = {2'b00, radicand};
    side[0] = side_in;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [SqW+1:0] rem_sh;
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rad_sh;
    always_comb begin
      // bring down the next two radicand bits
      rem_sh = {rem[s][SqW-1:0], rad[s][2*N-1 -: 2]};
      trial  = {{(SqW+2-LenW-2){1'b0}}, res[s], 2'b01};
      rad_sh = {rad[s][SqW-1:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[s+1]  <= rad_sh;
        side[s+1] <= side[s];
        if (rem_sh >= trial) begin
          rem[s+1] <= rem_sh - trial;
          res[s+1] <= {res[s][LenW-2:0], 1'b1};
        end else begin
          rem[s+1] <= rem_sh;
          res[s+1] <= {res[s][LenW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N];
  assign side_out  = side[N];
endmodule
`default_nettype wire

// ===== rtl/core/sbf2d_div.sv =====
// pipelined restoring divider: 99-bit dividend by 33-bit divisor, saturating
// quotient at 2^32-1; depends on sbf2d_pkg
`default_nettype none
module sbf2d_div
  import sbf2d_pkg::*;
#(
  parameter int SideW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [MW+MagW:0]  dividend,
  input  wire logic [LenW-1:0]   divisor,
  input  wire logic [SideW-1:0]  side_in,
  output logic                   out_valid,
  output logic [31:0]            quot,
  output logic [SideW-1:0]       side_out
);
  localparam int NW = MW + MagW + 1;   // dividend width, 99
  // quotient bits above 32 only mark overflow
  logic [NW:0]        vld;
  logic [LenW:0]      rem  [NW+1];
  logic [NW-1:0]      num  [NW+1];
  logic [31:0]        q    [NW+1];
  logic               ovf  [NW+1];
  logic [LenW-1:0]    dv   [NW+1];
  logic [SideW-1:0]   side [NW+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    num[0]  = dividend;
    q[0]    = '0;
    ovf[0]  = 1'b0;
    dv[0]   = divisor;
    side[0] = side_in;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [LenW+1:0] rsh;
    logic [LenW+1:0] diff;
    logic            qb;
    always_comb begin
      rsh  = {rem[s], num[s][NW-1]};
      diff = rsh - {2'b00, dv[s]};
      qb   = (rsh >= {2'b00, dv[s]});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= qb ? diff[LenW:0] : rsh[LenW:0];
        num[s+1]  <= {num[s][NW-2:0], 1'b0};
        q[s+1]    <= {q[s][30:0], qb};
        ovf[s+1]  <= ovf[s] | q[s][31];
        dv[s+1]   <= dv[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[NW];
  assign quot      = ovf[NW] ? 32'hFFFF_FFFF : q[NW];
  assign side_out  = side[NW];
endmodule
`default_nettype wire
